>>> hw/rtl/frc_pkg.sv
// Shared types, codes and defaults for the fragment reassembly checker.
`timescale 1ns / 1ps

package frc_pkg;

   localparam int HEADER_BYTES_DEFAULT = 8;
   localparam int QUEUE_DEPTH_DEFAULT  = 2;

   localparam logic [15:0] MIN_FRAGMENT_RESET = 16'h0000;
   localparam logic [15:0] MAX_FRAGMENT_RESET = 16'hFFFF;
   localparam logic [23:0] QUOTA_RESET        = 24'hFFFFFF;

   localparam int CSR_INDEX_W = 2;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_FRAGMENT = 2'd0,
      CSR_MAX_FRAGMENT = 2'd1,
      CSR_QUOTA        = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_DONE      = 4'd0,
      ST_HELD      = 4'd1,
      ST_NO_HEADER = 4'd2,
      ST_TOO_BIG   = 4'd3,
      ST_NO_SPACE  = 4'd4,
      ST_BAD_COUNT = 4'd5,
      ST_BAD_FIRST = 4'd6,
      ST_TOO_SMALL = 4'd7,
      ST_MISMATCH  = 4'd8,
      ST_BAD_INDEX = 4'd9
   } status_type;

   typedef struct packed {
      logic [15:0] frag_bytes;
      logic [15:0] msg_id;
      logic [7:0]  total_frags;
      logic [7:0]  frag_index;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [23:0] message_bytes;
      logic [8:0]  message_frags;
   } rsp_type;

   typedef struct packed {
      logic [15:0] min_fragment_bytes;
      logic [15:0] max_fragment_bytes;
      logic [23:0] quota_bytes;
   } cfg_type;

   // stateless verdicts worked out by the front end
   typedef struct packed {
      logic header_short;
      logic too_big;
      logic total_zero;
      logic total_one;
      logic index_zero;
      logic too_small;
      logic index_last;
   } flags_type;

   typedef struct packed {
      req_type   req;
      flags_type flags;
   } class_type;

endpackage

>>> hw/rtl/fragment_reassembly_checker_unit.sv
// Top level of the fragment reassembly checker: CSRs, front end, queues, back end.
`timescale 1ns / 1ps
// Path: an accepted request is registered in the work queue, judged by the back
// end as it is pushed into the response queue, and popped from there.
// Throughput: one request per cycle while the response queue has room; the
// back end's held-message registers, read and updated in the same cycle, set it.
// Reset (synchronous): partial message cleared, both queues emptied, CSRs
// back to min 0, max 65535, quota 16777215.

module fragment_reassembly_checker_unit #(
   parameter int HEADER_BYTES = frc_pkg::HEADER_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH  = frc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request side
   input  logic                            req_push,
   input  frc_pkg::req_type                req_data,
   output logic                            req_full,
   // response side
   output logic                            rsp_empty,
   output frc_pkg::rsp_type                rsp_data,
   input  logic                            rsp_pop,
   // CSR write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [frc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [23:0]                     csr_data
);

   localparam int CLASS_W = $bits(frc_pkg::class_type);
   localparam int RSP_W   = $bits(frc_pkg::rsp_type);

   // CSRs; always ready; writes must only arrive while idle, the block does not enforce it
   frc_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (frc_pkg::csr_index_type'(csr_index))
            frc_pkg::CSR_MIN_FRAGMENT: cfg_in.min_fragment_bytes = csr_data[15:0];
            frc_pkg::CSR_MAX_FRAGMENT: cfg_in.max_fragment_bytes = csr_data[15:0];
            frc_pkg::CSR_QUOTA:        cfg_in.quota_bytes        = csr_data;
            default:                   cfg_in = cfg_ff;   // unmapped index ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_fragment_bytes <= frc_pkg::MIN_FRAGMENT_RESET;
         cfg_ff.max_fragment_bytes <= frc_pkg::MAX_FRAGMENT_RESET;
         cfg_ff.quota_bytes        <= frc_pkg::QUOTA_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: stateless checks, result goes into the work queue
   frc_pkg::class_type classified;
   frc_pkg::class_type work_item;
   logic               work_empty;
   logic               work_full;
   logic               back_go;

   frc_front #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_front (
      .req        (req_data),
      .cfg        (cfg_ff),
      .classified (classified)
   );

   assign req_full = work_full;

   frc_queue #(
      .WIDTH (CLASS_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_work_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (classified),
      .full      (work_full),
      .pop       (back_go),
      .pop_data  (work_item),
      .empty     (work_empty)
   );

   // back end: runs whenever a request waits and the response queue has room
   frc_pkg::rsp_type back_rsp;
   logic             out_full;

   assign back_go = !work_empty && !out_full;

   frc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .valid       (back_go),
      .item        (work_item),
      .quota_bytes (cfg_ff.quota_bytes),
      .rsp         (back_rsp)
   );

   frc_queue #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_go),
      .push_data (back_rsp),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   // checks
   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> !work_empty)
      else $error("accepted request did not reach the work queue");

   a_done_counts : assert property (@(posedge clock) disable iff (reset)
      (back_go && back_rsp.status == frc_pkg::ST_DONE) |-> (back_rsp.message_frags != 9'd0))
      else $error("completed message reported with no fragments");

   a_zero_unless_done : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != frc_pkg::ST_DONE)
         |-> (rsp_data.message_bytes == 24'd0 && rsp_data.message_frags == 9'd0))
      else $error("non-completion response carries message totals");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule

>>> hw/rtl/frc_queue.sv
// Small register queue used between stages and on the response side.
`timescale 1ns / 1ps

module frc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/frc_front.sv
// Front end: classifies each request against header and size limits and flags its fragment count and index.
`timescale 1ns / 1ps

module frc_front #(
   parameter int HEADER_BYTES = frc_pkg::HEADER_BYTES_DEFAULT
) (
   input  frc_pkg::req_type   req,
   input  frc_pkg::cfg_type   cfg,
   output frc_pkg::class_type classified
);

   always_comb begin
      classified.req                = req;
      classified.flags.header_short = (req.frag_bytes < 16'(HEADER_BYTES));
      classified.flags.too_big      = (req.frag_bytes > cfg.max_fragment_bytes);
      classified.flags.total_zero   = (req.total_frags == 8'd0);
      classified.flags.total_one    = (req.total_frags == 8'd1);
      classified.flags.index_zero   = (req.frag_index == 8'd0);
      classified.flags.too_small    = (req.frag_bytes < cfg.min_fragment_bytes);
      classified.flags.index_last   = (req.frag_index == req.total_frags - 8'd1);
   end

endmodule

>>> hw/rtl/frc_back.sv
// Back end: holds the partial message and decides each fragment's outcome.
`timescale 1ns / 1ps

module frc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid,
   input  frc_pkg::class_type item,
   input  logic [23:0]        quota_bytes,
   output frc_pkg::rsp_type   rsp
);

   logic [15:0] held_msg_id_ff, held_msg_id_in;
   logic [7:0]  held_total_ff, held_total_in;
   logic [7:0]  held_last_index_ff, held_last_index_in;
   logic [8:0]  held_count_ff, held_count_in;
   logic [23:0] held_bytes_ff, held_bytes_in;

   logic        same_msg;
   logic [8:0]  base_count;
   logic [23:0] base_bytes;
   logic [24:0] quota_sum;
   logic [8:0]  next_index;
   logic [8:0]  sum_count;
   logic [23:0] sum_bytes;
   logic        do_append, do_clear;
   frc_pkg::status_type status;

   assign quota_sum  = {1'b0, held_bytes_ff} + 25'(item.req.frag_bytes);
   assign same_msg   = (held_count_ff != 9'd0) && (held_msg_id_ff == item.req.msg_id);
   // a changed id drops the partial message before the sequence checks
   assign base_count = same_msg ? held_count_ff : 9'd0;
   assign base_bytes = same_msg ? held_bytes_ff : 24'd0;
   assign next_index = {1'b0, held_last_index_ff} + 9'd1;
   assign sum_count  = base_count + 9'd1;
   assign sum_bytes  = base_bytes + 24'(item.req.frag_bytes);

   always_comb begin
      status    = frc_pkg::ST_HELD;
      do_append = 1'b0;
      do_clear  = 1'b1;
      if (item.flags.header_short) begin
         status = frc_pkg::ST_NO_HEADER;
      end else if (item.flags.too_big) begin
         status = frc_pkg::ST_TOO_BIG;
      end else if (quota_sum > {1'b0, quota_bytes}) begin
         status = frc_pkg::ST_NO_SPACE;
      end else if (item.flags.total_zero) begin
         status = frc_pkg::ST_BAD_COUNT;
      end else if (item.flags.total_one) begin
         status = frc_pkg::ST_DONE;
      end else if (base_count == 9'd0) begin
         if (!item.flags.index_zero) begin
            status = frc_pkg::ST_BAD_FIRST;
         end else if (item.flags.too_small) begin
            status = frc_pkg::ST_TOO_SMALL;
         end else begin
            do_append = 1'b1;
            do_clear  = 1'b0;
         end
      end else if (held_total_ff != item.req.total_frags) begin
         status = frc_pkg::ST_MISMATCH;
      end else if ({1'b0, item.req.frag_index} != next_index) begin
         status = frc_pkg::ST_BAD_INDEX;
      end else if (item.flags.index_last) begin
         status = frc_pkg::ST_DONE;
      end else if (item.flags.too_small) begin
         status = frc_pkg::ST_TOO_SMALL;
      end else begin
         do_append = 1'b1;
         do_clear  = 1'b0;
      end
   end

   always_comb begin
      rsp.status        = status;
      rsp.message_bytes = 24'd0;
      rsp.message_frags = 9'd0;
      if (status == frc_pkg::ST_DONE) begin
         rsp.message_bytes = sum_bytes;
         rsp.message_frags = sum_count;
      end
   end

   always_comb begin
      held_msg_id_in     = held_msg_id_ff;
      held_total_in      = held_total_ff;
      held_last_index_in = held_last_index_ff;
      held_count_in      = held_count_ff;
      held_bytes_in      = held_bytes_ff;
      if (valid) begin
         if (do_append) begin
            held_msg_id_in     = item.req.msg_id;
            held_total_in      = item.req.total_frags;
            held_last_index_in = item.req.frag_index;
            held_count_in      = sum_count;
            held_bytes_in      = sum_bytes;
         end else if (do_clear) begin
            held_msg_id_in     = 16'd0;
            held_total_in      = 8'd0;
            held_last_index_in = 8'd0;
            held_count_in      = 9'd0;
            held_bytes_in      = 24'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_msg_id_ff     <= 16'd0;
         held_total_ff      <= 8'd0;
         held_last_index_ff <= 8'd0;
         held_count_ff      <= 9'd0;
         held_bytes_ff      <= 24'd0;
      end else begin
         held_msg_id_ff     <= held_msg_id_in;
         held_total_ff      <= held_total_in;
         held_last_index_ff <= held_last_index_in;
         held_count_ff      <= held_count_in;
         held_bytes_ff      <= held_bytes_in;
      end
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the fragment reassembly checker: directed then random requests.

// Tracks the partial message as the checker should, and holds the verdicts still owed.
class reassembly_scoreboard;
   logic [15:0]      min_bytes;
   logic [15:0]      max_bytes;
   logic [23:0]      quota;
   logic [15:0]      held_id;
   logic [7:0]       held_total;
   logic [7:0]       held_last;
   logic [8:0]       held_count;
   logic [23:0]      held_bytes;
   frc_pkg::rsp_type verdicts_due[$];
   int               failures;

   function new();
      min_bytes = frc_pkg::MIN_FRAGMENT_RESET;
      max_bytes = frc_pkg::MAX_FRAGMENT_RESET;
      quota     = frc_pkg::QUOTA_RESET;
      failures  = 0;
      drop_partial();
   endfunction

   function void drop_partial();
      held_id    = '0;
      held_total = '0;
      held_last  = '0;
      held_count = '0;
      held_bytes = '0;
   endfunction

   function void absorb(frc_pkg::req_type r);
      held_id    = r.msg_id;
      held_total = r.total_frags;
      held_last  = r.frag_index;
      held_count = held_count + 9'd1;
      held_bytes = held_bytes + {8'd0, r.frag_bytes};
   endfunction

   function void write_register(frc_pkg::csr_index_type idx, logic [23:0] value);
      case (idx)
         frc_pkg::CSR_MIN_FRAGMENT: min_bytes = value[15:0];
         frc_pkg::CSR_MAX_FRAGMENT: max_bytes = value[15:0];
         frc_pkg::CSR_QUOTA:        quota     = value;
         default: ;
      endcase
   endfunction

   function frc_pkg::rsp_type predict_verdict(frc_pkg::req_type r);
      frc_pkg::rsp_type    res;
      frc_pkg::status_type st;
      logic [24:0]         need;
      res  = '0;
      need = {9'd0, r.frag_bytes} + {1'b0, held_bytes};
      if (r.frag_bytes < frc_pkg::HEADER_BYTES_DEFAULT) st = frc_pkg::ST_NO_HEADER;
      else if (r.frag_bytes > max_bytes) st = frc_pkg::ST_TOO_BIG;
      else if (need > {1'b0, quota}) st = frc_pkg::ST_NO_SPACE;
      else begin
         // another id silently drops whatever was held
         if (held_count != 0 && held_id != r.msg_id) drop_partial();
         if (r.total_frags == 8'd0) st = frc_pkg::ST_BAD_COUNT;
         else if (r.total_frags == 8'd1) begin
            absorb(r);
            st = frc_pkg::ST_DONE;
         end else if (held_count == 0) begin
            if (r.frag_index != 8'd0) st = frc_pkg::ST_BAD_FIRST;
            else if (r.frag_bytes < min_bytes) st = frc_pkg::ST_TOO_SMALL;
            else begin
               absorb(r);
               st = frc_pkg::ST_HELD;
            end
         end else if (held_total != r.total_frags) st = frc_pkg::ST_MISMATCH;
         else if ({1'b0, r.frag_index} != {1'b0, held_last} + 9'd1)
            st = frc_pkg::ST_BAD_INDEX;
         else if (r.frag_index == r.total_frags - 8'd1) begin
            absorb(r);
            st = frc_pkg::ST_DONE;
         end else if (r.frag_bytes < min_bytes) st = frc_pkg::ST_TOO_SMALL;
         else begin
            absorb(r);
            st = frc_pkg::ST_HELD;
         end
      end
      res.status = st;
      if (st == frc_pkg::ST_DONE) begin
         res.message_bytes = held_bytes;
         res.message_frags = held_count;
      end
      if (st != frc_pkg::ST_HELD) drop_partial();
      return res;
   endfunction

   function int pending();
      return verdicts_due.size();
   endfunction

   function void note_fragment(frc_pkg::req_type r);
      verdicts_due.push_back(predict_verdict(r));
   endfunction

   function void check_verdict(frc_pkg::rsp_type got);
      frc_pkg::rsp_type want;
      if (verdicts_due.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("verdict with none owed: status %0d bytes %0d frags %0d",
                     got.status, got.message_bytes, got.message_frags);
         return;
      end
      want = verdicts_due.pop_front();
      if (got.status !== want.status || got.message_bytes !== want.message_bytes ||
          got.message_frags !== want.message_frags) begin
         failures++;
         if (failures <= 10)
            $display("verdict mismatch: status %0d/%0d bytes %0d/%0d frags %0d/%0d (exp/got)",
                     want.status, got.status, want.message_bytes, got.message_bytes,
                     want.message_frags, got.message_frags);
      end
   endfunction
endclass

module testbench;
   localparam int HEADER_BYTES = frc_pkg::HEADER_BYTES_DEFAULT;
   // far beyond the slowest legal run
   localparam int CYCLE_LIMIT  = 400000;

   logic               clock;
   logic               reset;
   logic               req_push;
   frc_pkg::req_type   req_data;
   logic               req_full;
   logic               rsp_empty;
   frc_pkg::rsp_type   rsp_data;
   logic               rsp_pop;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [23:0]        csr_data;

   reassembly_scoreboard scoreboard;

   int            fragments_sent;
   int            cycles = 0;
   int            send_idle_pct;  // chance per request slot that the sender holds off
   int            pop_stall_pct;  // chance per cycle that the receiver refuses to pop
   int            cfg_min;        // stimulus copy of the limits, to shape fragment sizes
   int            cfg_max;
   logic [15:0]   last_msg_id;

   fragment_reassembly_checker_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Run guard: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[fragment_reassembly_checker_unit] ERROR");
         $finish;
      end
   end

   // Both handshakes are observed here, at the rising edge, on values driven at the
   // falling edge. A verdict can never belong to a request taken at the same edge,
   // so checking before noting is safe.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) scoreboard.check_verdict(rsp_data);
         if (req_push && !req_full) scoreboard.note_fragment(req_data);
      end
   end

   // Receiver: pops at random, held off as the current idling phase says.
   always @(negedge clock)
      rsp_pop = !reset && ($urandom_range(99) >= pop_stall_pct);

   function automatic frc_pkg::req_type frag(int bytes, int id, int total, int idx);
      frc_pkg::req_type r;
      r.frag_bytes  = bytes[15:0];
      r.msg_id      = id[15:0];
      r.total_frags = total[7:0];
      r.frag_index  = idx[7:0];
      return r;
   endfunction

   // Fully random header and size; also used as junk on the bus while idle.
   function automatic frc_pkg::req_type random_fragment();
      frc_pkg::req_type r;
      r.frag_bytes  = ($urandom_range(3) == 0) ? 16'($urandom_range(15))
                                               : 16'($urandom_range(65535));
      r.msg_id      = 16'($urandom_range(65535));
      r.total_frags = ($urandom_range(1) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(4));
      r.frag_index  = ($urandom_range(1) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(4));
      return r;
   endfunction

   // Sizes within the current limits, edges favoured; junk if the limits leave no room.
   function automatic logic [15:0] pick_size(bit final_frag);
      int lo;
      int hi;
      lo = (final_frag || cfg_min < HEADER_BYTES) ? HEADER_BYTES : cfg_min;
      hi = cfg_max;
      if (hi < lo) return 16'($urandom_range(65535));
      case ($urandom_range(9))
         0:       return 16'(lo);
         1:       return 16'(hi);
         default: return 16'($urandom_range(hi, lo));
      endcase
   endfunction

   // One request: random hold-off, then hold push until it is taken.
   task automatic push_fragment(input frc_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_push = 1'b0;
         req_data = random_fragment();
      end
      @(negedge clock);
      req_push = 1'b1;
      req_data = r;
      @(posedge clock);
      while (req_full) @(posedge clock);
      fragments_sent++;
   endtask

   // Sender pauses until every owed verdict has been popped.
   task automatic wait_drained();
      @(negedge clock);
      req_push = 1'b0;
      while (scoreboard.pending() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input frc_pkg::csr_index_type idx, input int value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value[23:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      scoreboard.write_register(idx, value[23:0]);
      if (idx == frc_pkg::CSR_MIN_FRAGMENT) cfg_min = value;
      if (idx == frc_pkg::CSR_MAX_FRAGMENT) cfg_max = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Limits only change with the checker idle: drained and quiet before the CSR writes.
   task automatic configure(input int min_b, input int max_b, input int quota_b);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_write(frc_pkg::CSR_MIN_FRAGMENT, min_b);
      csr_write(frc_pkg::CSR_MAX_FRAGMENT, max_b);
      csr_write(frc_pkg::CSR_QUOTA, quota_b);
   endtask

   // A whole message with random content; some are cut short or carry one bad fragment.
   task automatic send_message(input int forced_total);
      frc_pkg::req_type r;
      int               total;
      int               sent_frags;
      int               fault_at;
      logic [15:0]      id;
      id = ($urandom_range(3) == 0) ? last_msg_id : 16'($urandom_range(65535));
      if (forced_total != 0) total = forced_total;
      else if ($urandom_range(99) < 15) total = 1;
      else if ($urandom_range(99) < 90) total = $urandom_range(6, 2);
      else total = $urandom_range(24, 7);
      sent_frags = (total > 1 && $urandom_range(9) == 0) ? $urandom_range(total - 1, 1) : total;
      fault_at   = ($urandom_range(99) < 12) ? $urandom_range(total - 1) : -1;
      for (int k = 0; k < sent_frags; k++) begin
         r = frag(pick_size(k == total - 1), id, total, k);
         if (k == fault_at) begin
            case ($urandom_range(6))
               0:       r.frag_index  = r.frag_index + 8'd1;   // skipped fragment
               1:       r.frag_index  = r.frag_index - 8'd1;   // repeat, or wraps at the start
               2:       r.total_frags = 8'($urandom_range(255));
               3:       r.msg_id      = 16'($urandom_range(65535)); // stray id mid-message
               4:       r.frag_bytes  = 16'($urandom_range(HEADER_BYTES - 1));
               5:       r.frag_bytes  = 16'($urandom_range(65535));
               default: r.total_frags = 8'd0;
            endcase
         end
         push_fragment(r);
      end
      last_msg_id = id;
   endtask

   // Mostly well-formed messages, a tenth pure noise; an occasional full drain.
   task automatic run_traffic(input int count);
      int goal;
      goal = fragments_sent + count;
      while (fragments_sent < goal) begin
         if ($urandom_range(9) == 0) push_fragment(random_fragment());
         else send_message(0);
         if ($urandom_range(199) == 0) wait_drained();
      end
   endtask

   initial begin
      scoreboard     = new();
      reset          = 1'b1;
      req_push       = 1'b0;
      req_data       = '0;
      csr_valid      = 1'b0;
      csr_index      = frc_pkg::CSR_MIN_FRAGMENT;
      csr_data       = '0;
      fragments_sent = 0;
      send_idle_pct  = 0;
      pop_stall_pct  = 0;
      cfg_min        = frc_pkg::MIN_FRAGMENT_RESET;
      cfg_max        = frc_pkg::MAX_FRAGMENT_RESET;
      last_msg_id    = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Directed, reset limits, no idling
      push_fragment(frag(0, 16'h0001, 1, 0));        // no header
      push_fragment(frag(7, 16'h0001, 1, 0));        // one byte short of a header
      push_fragment(frag(8, 16'h0000, 1, 0));        // bare header, single fragment
      push_fragment(frag(65535, 16'hFFFF, 1, 255));  // largest single fragment
      push_fragment(frag(100, 2, 0, 0));             // zero fragment count
      push_fragment(frag(100, 3, 3, 1));             // starts mid-message
      push_fragment(frag(255, 16'hFFFF, 255, 255));  // starts at the top index
      push_fragment(frag(100, 4, 3, 0));
      push_fragment(frag(200, 4, 3, 1));
      push_fragment(frag(300, 4, 3, 1));             // repeated index
      push_fragment(frag(100, 5, 3, 0));
      push_fragment(frag(100, 5, 4, 1));             // count changes mid-message
      push_fragment(frag(100, 6, 3, 0));
      push_fragment(frag(50, 6, 1, 0));              // single-fragment header on held data
      push_fragment(frag(100, 7, 2, 0));
      push_fragment(frag(120, 8, 2, 0));             // new id drops message 7
      push_fragment(frag(130, 8, 2, 1));
      push_fragment(frag(10, 9, 3, 0));
      push_fragment(frag(20, 9, 3, 1));
      push_fragment(frag(30, 9, 3, 2));              // clean three-fragment message
      push_fragment(frag(40, 9, 2, 2));
      run_traffic(160);

      // Tight limits: size bounds and quota
      configure(100, 200, 300);
      send_idle_pct = 83;
      push_fragment(frag(201, 10, 1, 0));            // over the maximum
      push_fragment(frag(65535, 10, 1, 0));
      push_fragment(frag(50, 10, 2, 0));             // first fragment under the minimum
      push_fragment(frag(150, 11, 2, 0));
      push_fragment(frag(50, 11, 2, 1));             // a short final fragment is fine
      push_fragment(frag(200, 12, 2, 0));
      push_fragment(frag(150, 12, 2, 1));            // quota exceeded
      push_fragment(frag(150, 13, 3, 0));
      push_fragment(frag(20, 13, 3, 1));             // short middle fragment
      push_fragment(frag(200, 14, 2, 0));
      push_fragment(frag(150, 15, 1, 0));            // quota checked before the id change
      run_traffic(160);

      configure(0, 65535, 24'hFFFFFF);
      send_idle_pct = 0;
      pop_stall_pct = 83;
      send_message(255);                             // longest possible message
      run_traffic(180);

      configure(65535, 65535, 24'hFFFFFF);
      send_idle_pct = 31;
      pop_stall_pct = 31;
      run_traffic(180);

      configure(0, 0, 0);                            // nothing can pass
      send_idle_pct = 0;
      pop_stall_pct = 0;
      run_traffic(60);

      configure(8, 1500, 4000);
      send_idle_pct = 83;
      run_traffic(180);

      configure(500, 600, 24'hFFFFFF);
      send_idle_pct = 0;
      pop_stall_pct = 83;
      run_traffic(160);

      configure(20, 300, 1000);
      send_idle_pct = 31;
      pop_stall_pct = 31;
      run_traffic(160);

      wait_drained();
      repeat (8) @(negedge clock);
      if (scoreboard.pending() != 0) begin
         $display("%0d verdicts never arrived", scoreboard.pending());
         scoreboard.failures += scoreboard.pending();
      end
      if (scoreboard.failures == 0) $display("[fragment_reassembly_checker_unit] OK");
      else $display("[fragment_reassembly_checker_unit] ERROR");
      $finish;
   end
endmodule

>>> filelist.f
hw/rtl/frc_pkg.sv
hw/rtl/frc_queue.sv
hw/rtl/frc_front.sv
hw/rtl/frc_back.sv
hw/rtl/fragment_reassembly_checker_unit.sv
bench/testbench.sv
